@@ sv/open_addressing_hash_insert_defines.svh @@
// assertion macros shared by the hash insert engine
// no dependencies; taken in by `include where assertions are written
`ifndef OPEN_ADDRESSING_HASH_INSERT_DEFINES_SVH
`define OPEN_ADDRESSING_HASH_INSERT_DEFINES_SVH

// same-cycle implication, off while reset is asserted
`define OAHI_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, off while reset is asserted
`define OAHI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/oahi_pkg.sv @@
// constants and codes of the open-addressing hash insert engine
// no dependencies; used by open_addressing_hash_insert
`default_nettype none

package oahi_pkg;

	// slot store depth
	localparam int TABLE_DEPTH = 16;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);

	// field widths
	localparam int KEY_W    = 31;
	localparam int SIZE_W   = 5;
	localparam int SLOT_W   = 4;
	localparam int CNT_W    = 5;
	localparam int STATUS_W = 2;
	localparam int KEYBIT_W = $clog2(KEY_W);

	// stored entry: occupied flag over the key
	localparam int ENTRY_W = KEY_W + 1;

	// double hashing prime and step width
	localparam int DH_PRIME = 7;
	localparam int STEP_W   = $clog2(DH_PRIME + 1);

	// sum of the base-eight digits of a key, at most 71
	localparam int DSUM_W = 7;

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 5;
	localparam logic [CFG_IDX_W-1:0] REG_TABLE_SIZE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PROBE_MODE = 1'd1;

	// reset values of the registers
	localparam logic [SIZE_W-1:0] TABLE_SIZE_RST = 5'd10;

	// item kinds
	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_CLEAR  = 1'b1;

	// probing modes
	localparam logic MODE_LINEAR = 1'b0;
	localparam logic MODE_DOUBLE = 1'b1;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_PLACED  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
	localparam logic [STATUS_W-1:0] ST_CLEARED = 2'd2;

endpackage

`default_nettype wire

@@ sv/open_addressing_hash_insert.sv @@
// open-addressing hash table insert engine, linear or double-hashing probes
// depends on oahi_pkg, oahi_ram and open_addressing_hash_insert_defines.svh
//
//  channel   signals                               transfer when
//  -------   -----------------------------------   ------------------------
//  input     in_valid, in_ready, kind, key         in_valid && in_ready
//  output    out_valid, out_ready, slot_index,     out_valid && out_ready
//            probe_count, status
//  config    cfg_we, cfg_idx, cfg_wdata            cfg_we (no wait)
//
// one item at a time. an insert first forms key mod n bit-serially (key mod 7
// comes from a base-eight digit sum meanwhile), then reduces the step modulo n,
// then reads one slot per cycle from the slot ram until an empty slot is found
// or all n slots are passed, then loads the result into the output register.
// a clear item sweeps all 16 slot ram entries, one a cycle, then reports.
// after reset the same sweep empties the ram; no input is taken meanwhile,
// configuration writes are. a result waiting in the output register does not
// stop the next item from being taken, only its result.
`default_nettype none

module open_addressing_hash_insert (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// configuration
	input  wire logic                             cfg_we,
	input  wire logic [oahi_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  wire logic [oahi_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	// input items
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic                             kind,
	input  wire logic [oahi_pkg::KEY_W-1:0]       key,
	// results
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic      [oahi_pkg::SLOT_W-1:0]      slot_index,
	output logic      [oahi_pkg::CNT_W-1:0]       probe_count,
	output logic      [oahi_pkg::STATUS_W-1:0]    status
);

	import oahi_pkg::*;

	`include "open_addressing_hash_insert_defines.svh"

	// sequencer codes
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_INIT  = 3'd1;
	localparam logic [2:0] S_DIV   = 3'd2;
	localparam logic [2:0] S_STEP  = 3'd3;
	localparam logic [2:0] S_PROBE = 3'd4;
	localparam logic [2:0] S_DONE  = 3'd5;

	logic [2:0]          state_q;
	logic [SIZE_W-1:0]   table_size_q;
	logic                probe_mode_q;
	logic [IDX_W-1:0]    sweep_q;
	logic                clr_res_q;
	logic [KEY_W-1:0]    key_q;
	logic [KEYBIT_W-1:0] bit_q;
	logic [SIZE_W-1:0]   rem_n_q;
	logic [DSUM_W-1:0]   dsum_q;
	logic [STEP_W-1:0]   step_q;
	logic [SIZE_W-1:0]   iss_pos_q;
	logic [CNT_W-1:0]    iss_cnt_q;
	logic                chk_vld_s1;
	logic [SIZE_W-1:0]   chk_pos_s1;
	logic [CNT_W-1:0]    chk_cnt_s1;
	logic [SLOT_W-1:0]   res_slot_q;
	logic [CNT_W-1:0]    res_cnt_q;
	logic [STATUS_W-1:0] res_status_q;
	logic                out_valid_q;
	logic [SLOT_W-1:0]   out_slot_q;
	logic [CNT_W-1:0]    out_cnt_q;
	logic [STATUS_W-1:0] out_status_q;

	logic [SIZE_W-1:0]   n_act;
	logic                key_bit;
	logic [SIZE_W:0]     rem_n_t;
	logic [SIZE_W-1:0]   rem_n_nxt;
	logic [DSUM_W-1:0]   dsum;
	logic [4:0]          fold1;
	logic [3:0]          fold2;
	logic [STEP_W-1:0]   key_mod7;
	logic [STEP_W-1:0]   step_init;
	logic [SIZE_W:0]     pos_sum;
	logic [SIZE_W-1:0]   pos_nxt;
	logic                occupied;
	logic                place;
	logic                full;
	logic                issue;
	logic                out_load;

	logic                ram_we;
	logic [IDX_W-1:0]    ram_waddr;
	logic [ENTRY_W-1:0]  ram_wdata;
	logic [IDX_W-1:0]    ram_raddr;
	logic [ENTRY_W-1:0]  ram_rdata;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_size_q <= TABLE_SIZE_RST;
			probe_mode_q <= MODE_LINEAR;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_TABLE_SIZE: table_size_q <= cfg_wdata;
				REG_PROBE_MODE: probe_mode_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// slots in use: zero means one, saturate at the store depth
	always_comb begin
		if (table_size_q == '0) begin
			n_act = SIZE_W'(1);
		end else if (int'(table_size_q) > TABLE_DEPTH) begin
			n_act = SIZE_W'(TABLE_DEPTH);
		end else begin
			n_act = table_size_q;
		end
	end

	// one remainder bit a cycle for key mod n
	assign key_bit   = key_q[bit_q];
	assign rem_n_t   = {rem_n_q, key_bit};
	assign rem_n_nxt = (rem_n_t >= {1'b0, n_act}) ? SIZE_W'(rem_n_t - {1'b0, n_act})
		: SIZE_W'(rem_n_t);

	// key mod 7 from its base-eight digits, eight being one modulo seven
	always_comb begin
		dsum = DSUM_W'(key_q[KEY_W-1]);
		for (int d = 0; d < KEY_W / 3; d++) begin
			dsum = dsum + DSUM_W'(key_q[3*d +: 3]);
		end
	end

	// fold the registered digit sum twice, then one compare and subtract
	assign fold1     = 5'(dsum_q[6:3]) + 5'(dsum_q[2:0]);
	assign fold2     = 4'(fold1[4:3]) + 4'(fold1[2:0]);
	assign key_mod7  = (fold2 >= 4'(DH_PRIME)) ? STEP_W'(fold2 - 4'(DH_PRIME))
		: STEP_W'(fold2);
	assign step_init = (probe_mode_q == MODE_DOUBLE) ? STEP_W'(DH_PRIME) - key_mod7
		: STEP_W'(1);

	// next probe position, both terms below n
	assign pos_sum = {1'b0, iss_pos_q} + (SIZE_W+1)'(step_q);
	assign pos_nxt = (pos_sum >= {1'b0, n_act}) ? SIZE_W'(pos_sum - {1'b0, n_act})
		: SIZE_W'(pos_sum);

	// probe check on the read data of the slot issued last cycle
	assign occupied = ram_rdata[KEY_W];
	assign place    = (state_q == S_PROBE) && chk_vld_s1 && !occupied;
	assign full     = (state_q == S_PROBE) && chk_vld_s1 && occupied
		&& (chk_cnt_s1 == CNT_W'(n_act - SIZE_W'(1)));
	assign issue    = CNT_W'(iss_cnt_q) < CNT_W'(n_act);

	// slot ram ports: sweep writes empty entries, a placement writes the key
	assign ram_we    = (state_q == S_INIT) || place;
	assign ram_waddr = (state_q == S_INIT) ? sweep_q : IDX_W'(chk_pos_s1);
	assign ram_wdata = (state_q == S_INIT) ? '0 : {1'b1, key_q};
	assign ram_raddr = IDX_W'(iss_pos_q);

	oahi_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_DEPTH)
	) u_slot_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign in_ready = (state_q == S_IDLE);
	assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_INIT;
			sweep_q    <= '0;
			clr_res_q  <= 1'b0;
			chk_vld_s1 <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (kind == KIND_CLEAR) begin
							state_q   <= S_INIT;
							sweep_q   <= '0;
							clr_res_q <= 1'b1;
						end else begin
							state_q <= S_DIV;
						end
					end
				end
				S_INIT: begin
					sweep_q <= sweep_q + IDX_W'(1);
					if (sweep_q == IDX_W'(TABLE_DEPTH - 1)) begin
						state_q <= clr_res_q ? S_DONE : S_IDLE;
					end
				end
				S_DIV: begin
					if (bit_q == '0) begin
						state_q <= S_STEP;
					end
				end
				S_STEP: begin
					if ({{(SIZE_W-STEP_W){1'b0}}, step_q} < n_act) begin
						state_q    <= S_PROBE;
						chk_vld_s1 <= 1'b0;
					end
				end
				S_PROBE: begin
					if (place || full) begin
						state_q    <= S_DONE;
						chk_vld_s1 <= 1'b0;
					end else begin
						chk_vld_s1 <= issue;
					end
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// item datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				key_q   <= key;
				bit_q   <= KEYBIT_W'(KEY_W - 1);
				rem_n_q <= '0;
			end
			S_INIT: begin
				res_slot_q   <= '0;
				res_cnt_q    <= '0;
				res_status_q <= ST_CLEARED;
			end
			S_DIV: begin
				bit_q     <= bit_q - KEYBIT_W'(1);
				rem_n_q   <= rem_n_nxt;
				dsum_q    <= dsum;
				step_q    <= step_init;
				iss_pos_q <= rem_n_nxt;
				iss_cnt_q <= '0;
			end
			S_STEP: begin
				if ({{(SIZE_W-STEP_W){1'b0}}, step_q} >= n_act) begin
					step_q <= STEP_W'({{(SIZE_W-STEP_W){1'b0}}, step_q} - n_act);
				end
			end
			S_PROBE: begin
				if (place) begin
					res_slot_q   <= SLOT_W'(chk_pos_s1);
					res_cnt_q    <= chk_cnt_s1;
					res_status_q <= ST_PLACED;
				end else if (full) begin
					res_slot_q   <= '0;
					res_cnt_q    <= CNT_W'(n_act);
					res_status_q <= ST_FULL;
				end else if (issue) begin
					chk_pos_s1 <= iss_pos_q;
					chk_cnt_s1 <= iss_cnt_q;
					iss_pos_q  <= pos_nxt;
					iss_cnt_q  <= iss_cnt_q + CNT_W'(1);
				end
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_slot_q   <= res_slot_q;
			out_cnt_q    <= res_cnt_q;
			out_status_q <= res_status_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign slot_index  = out_slot_q;
	assign probe_count = out_cnt_q;
	assign status      = out_status_q;

	// checks
	`OAHI_ASSERT_SAME(a_place_empty, clk, arst_n,
		ram_we && (state_q == S_PROBE), !ram_rdata[KEY_W],
		"key written over an occupied slot")
	`OAHI_ASSERT_SAME(a_issue_bound, clk, arst_n,
		state_q == S_PROBE, CNT_W'(iss_cnt_q) <= CNT_W'(n_act),
		"more probes issued than slots in use")
	`OAHI_ASSERT_SAME(a_full_slot, clk, arst_n,
		out_valid && (status == ST_FULL), slot_index == '0,
		"full result with a non-zero slot")
	`OAHI_ASSERT_SAME(a_clear_res, clk, arst_n,
		out_valid && (status == ST_CLEARED), (slot_index == '0) && (probe_count == '0),
		"clear result with non-zero fields")
	`OAHI_ASSERT_NEXT(a_load_ready, clk, arst_n,
		out_load, state_q == S_IDLE,
		"sequencer not idle after result load")

endmodule

`default_nettype wire

@@ sv/oahi_ram.sv @@
// generic single-clock ram, one write port and one registered read port
// no dependencies
`default_nettype none

module oahi_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

@@ tb/sv/tb_open_addressing_hash_insert.sv @@
// self-checking testbench for the open-addressing hash insert engine
// depends on oahi_pkg and open_addressing_hash_insert; predicts every result and
// checks it under random sender bursts, receiver stalls and register changes
`default_nettype none

module tb_open_addressing_hash_insert;

	import oahi_pkg::*;

	typedef struct packed {
		logic             kind;
		logic [KEY_W-1:0] key;
	} hash_item_t;

	typedef struct packed {
		logic [SLOT_W-1:0]   slot;
		logic [CNT_W-1:0]    probes;
		logic [STATUS_W-1:0] st;
	} hash_result_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_idx   = REG_TABLE_SIZE;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	logic             in_valid = 1'b0;
	logic             in_ready;
	logic             kind     = KIND_INSERT;
	logic [KEY_W-1:0] key      = '0;

	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [SLOT_W-1:0]   slot_index;
	logic [CNT_W-1:0]    probe_count;
	logic [STATUS_W-1:0] status;

	// own copy of the registers and of the slot occupancy
	logic [SIZE_W-1:0] tb_size = TABLE_SIZE_RST;
	logic              tb_mode = MODE_LINEAR;
	logic              slot_occ [TABLE_DEPTH];

	hash_item_t   stim_q[$];
	hash_result_t placed_q[$];

	int unsigned err_cnt    = 0;
	int unsigned in_cnt     = 0;
	int          burst_left = 0;
	int          gap_left   = 0;
	logic [8:0]  rx_phase   = '0;
	logic        rx_hold    = 1'b0;

	open_addressing_hash_insert i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_idx     (cfg_idx),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.kind        (kind),
		.key         (key),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.slot_index  (slot_index),
		.probe_count (probe_count),
		.status      (status)
	);

	initial forever #5 clk = ~clk;

	// insert or clear against the predicted table, returns the expected result
	function automatic hash_result_t place_key(input logic k, input logic [KEY_W-1:0] kv);
		hash_result_t res;
		int unsigned  n;
		int unsigned  stride;
		int unsigned  pos;
		int unsigned  i;
		bit           done;
		res = '{slot: '0, probes: '0, st: ST_CLEARED};
		if (k == KIND_CLEAR) begin
			for (i = 0; i < TABLE_DEPTH; i++)
				slot_occ[i] = 1'b0;
		end else begin
			// size zero acts as one slot, sizes past the store saturate
			n = (tb_size == 0) ? 1 : ((tb_size > TABLE_DEPTH) ? TABLE_DEPTH : tb_size);
			stride = (tb_mode == MODE_DOUBLE) ? (DH_PRIME - (kv % DH_PRIME)) : 1;
			pos = kv % n;
			res.st = ST_FULL;
			res.probes = CNT_W'(n);
			done = 1'b0;
			for (i = 0; i < n && !done; i++) begin
				if (!slot_occ[pos]) begin
					slot_occ[pos] = 1'b1;
					res.slot = SLOT_W'(pos);
					res.probes = CNT_W'(i);
					res.st = ST_PLACED;
					done = 1'b1;
				end else begin
					pos = (pos + stride) % n;
				end
			end
		end
		return res;
	endfunction

	task automatic flag_mismatch(input string what, input hash_result_t want,
			input hash_result_t got);
		err_cnt++;
		if (err_cnt <= 10)
			$display("%s: expected slot %0d probes %0d status %0d, got slot %0d probes %0d status %0d",
				what, want.slot, want.probes, want.st, got.slot, got.probes, got.st);
	endtask

	task automatic push_item(input logic k, input logic [KEY_W-1:0] kv);
		stim_q.insert(stim_q.size(), '{kind: k, key: kv});
	endtask

	// mostly inserts with keys that collide, some clears so the table refills
	task automatic push_random(input int count);
		int          j;
		int unsigned r;
		logic [KEY_W-1:0] kv;
		for (j = 0; j < count; j++) begin
			r = $urandom_range(0, 99);
			if (r < 7) begin
				push_item(KIND_CLEAR, KEY_W'($urandom));
			end else begin
				if (r < 45)
					kv = KEY_W'($urandom_range(0, 63));
				else if (r < 75)
					kv = KEY_W'($urandom);
				else if (r < 88)
					kv = KEY_W'($urandom_range(0, 400) * DH_PRIME);
				else if (r < 94)
					kv = {KEY_W{1'b1}} - KEY_W'($urandom_range(0, 20));
				else
					kv = KEY_W'($urandom_range(0, 3));
				push_item(KIND_INSERT, kv);
			end
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= val;
		if (idx == REG_TABLE_SIZE)
			tb_size = SIZE_W'(val);
		else
			tb_mode = val[0];
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// table size then probing mode
	task automatic set_regs(input logic [SIZE_W-1:0] size, input logic mode);
		write_reg(REG_TABLE_SIZE, CFG_DATA_W'(size));
		write_reg(REG_PROBE_MODE, CFG_DATA_W'(mode));
	endtask

	task automatic wait_drained;
		@(negedge clk);
		while (stim_q.size() != 0 || in_valid || placed_q.size() != 0)
			@(negedge clk);
	endtask

	// sender: bursts of transfers with random gaps, predicts on each transfer
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid   <= 1'b0;
			kind       <= KIND_INSERT;
			key        <= '0;
			burst_left <= 0;
			gap_left   <= 0;
		end else begin
			if (in_valid && in_ready) begin
				placed_q.insert(placed_q.size(), place_key(kind, key));
				in_cnt <= in_cnt + 1;
			end
			if (!in_valid || in_ready) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (stim_q.size() != 0) begin
					in_valid <= 1'b1;
					kind     <= stim_q[0].kind;
					key      <= stim_q[0].key;
					void'(stim_q.pop_front());
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 40);
						gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: checks each result transfer, stall pattern steps through four kinds in turn
	always @(posedge clk or negedge arst_n) begin : rx_check
		hash_result_t want;
		hash_result_t got;
		logic         rdy;
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_phase  <= '0;
		end else begin
			if (out_valid && out_ready) begin
				got = '{slot: slot_index, probes: probe_count, st: status};
				if (placed_q.size() == 0) begin
					flag_mismatch("unexpected result", '0, got);
				end else begin
					want = placed_q.pop_front();
					if (got.slot !== want.slot || got.probes !== want.probes
							|| got.st !== want.st)
						flag_mismatch("result mismatch", want, got);
				end
			end
			rx_phase <= rx_phase + 1'b1;
			case (rx_phase[8:7])
				2'd0: rdy = 1'b1;
				2'd1: rdy = (rx_phase[1:0] != 2'd0);
				2'd2: rdy = 1'($urandom_range(0, 1));
				default: rdy = rx_phase[4];
			endcase
			out_ready <= rdy && !rx_hold;
		end
	end

	// long receiver hold-off while the sender keeps offering items
	initial begin
		while (!(in_cnt >= 300 && stim_q.size() > 30))
			@(posedge clk);
		rx_hold <= 1'b1;
		repeat (400) @(posedge clk);
		rx_hold <= 1'b0;
	end

	initial begin
		#5_000_000;
		$display("tb_open_addressing_hash_insert: FAIL");
		$finish;
	end

	// reset, directed items at reset settings, then random phases
	initial begin : stimulus
		int p;
		for (p = 0; p < TABLE_DEPTH; p++)
			slot_occ[p] = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// home slots, collisions, wrap-around and a full table at size ten
		push_item(KIND_INSERT, 31'd0);
		push_item(KIND_INSERT, 31'h7FFF_FFFF);
		push_item(KIND_INSERT, 31'd10);
		push_item(KIND_INSERT, 31'd20);
		push_item(KIND_CLEAR, 31'h7FFF_FFFF);
		push_item(KIND_INSERT, 31'd9);
		push_item(KIND_INSERT, 31'd19);
		for (p = 1; p <= 8; p++)
			push_item(KIND_INSERT, KEY_W'(p));
		push_item(KIND_INSERT, 31'd5);
		push_item(KIND_CLEAR, 31'd0);
		wait_drained();

		for (p = 0; p < 11; p++) begin
			case (p)
				0:  set_regs(5'd1, MODE_LINEAR);
				1:  set_regs(5'd16, MODE_DOUBLE);
				2:  set_regs(5'd16, MODE_LINEAR);
				3:  set_regs(5'd0, MODE_DOUBLE);
				4:  set_regs(5'd31, MODE_LINEAR);
				// step of seven never leaves the home slot here
				5:  set_regs(5'd7, MODE_DOUBLE);
				6:  set_regs(5'd14, MODE_DOUBLE);
				7:  set_regs(5'd13, MODE_LINEAR);
				8:  set_regs(5'd4, MODE_DOUBLE);
				9:  set_regs(5'd2, MODE_DOUBLE);
				default: set_regs(5'd9, MODE_DOUBLE);
			endcase
			push_random(110);
			wait_drained();
		end

		repeat (100) @(posedge clk);
		err_cnt += placed_q.size();
		if (err_cnt == 0)
			$display("tb_open_addressing_hash_insert: PASS");
		else
			$display("tb_open_addressing_hash_insert: FAIL");
		$finish;
	end

endmodule

`default_nettype wire
